### sv/signed_int_to_decimal_digits_unit_assert.svh
// Assertion macros for the signed decimal digit unit.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef SIGNED_INT_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SIDD_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("Assertion failed in signed decimal digit unit.");

// Next-cycle implication.
`define SIDD_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("Assertion failed in signed decimal digit unit.");

`endif

### sv/sidd_pkg.sv
// Shared types and constants for the signed decimal digit unit.
// No dependencies.
package sidd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned POS_W   = 3;
  localparam logic [3:0] MINUS_CODE = 4'd10;
  localparam logic [2:0] LAST_POS   = 3'd5;

  function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? (d + 4'd3) : d;
    return r;
  endfunction

endpackage

### sv/signed_int_to_decimal_digits_unit.sv
// Signed integer to decimal digit words, built on sidd_pkg and the assertion macro header.
// The first word becomes valid once the conversion has shifted in all VALUE_WIDTH bits, then
// one word per cycle unless out_ready stalls it. No new number is taken meanwhile: the shared
// shift-and-adjust unit keeps in_ready low until the run's last word is in the output register.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
module signed_int_to_decimal_digits_unit #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [3:0]             out_digit,
  output logic [2:0]             out_position,
  output logic                   out_last
);

  localparam int unsigned NDIG  = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int unsigned BCD_W = sidd_pkg::DIGIT_W * NDIG;
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

  sidd_pkg::state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   sign_r, sign_nxt;
  logic [2:0]             pos_r, pos_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [3:0]             digit_r, digit_nxt;
  logic [2:0]             opos_r, opos_nxt;
  logic                   last_r, last_nxt;

  logic [BCD_W-1:0]       bcd_adj;
  logic [BCD_W-1:0]       bcd_rest;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   in_neg;
  logic                   slot_free;
  logic                   at_max;

  assign in_ready     = (state_r == sidd_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_digit    = digit_r;
  assign out_position = opos_r;
  assign out_last     = last_r;

  assign in_neg    = in_value[VALUE_WIDTH-1];
  assign mag       = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
  assign slot_free = !out_valid_r || out_ready;
  assign bcd_rest  = bcd_r >> sidd_pkg::DIGIT_W;
  assign at_max    = (pos_r == sidd_pkg::LAST_POS);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = sidd_pkg::bcd_adjust(bcd_r[i*4 +: 4]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    sign_nxt      = sign_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    digit_nxt     = digit_r;
    opos_nxt      = opos_r;
    last_nxt      = last_r;
    case (state_r)
      sidd_pkg::ST_IDLE: begin
        if (in_valid) begin
          bin_nxt   = mag;
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_WIDTH);
          neg_nxt   = in_neg;
          sign_nxt  = 1'b0;
          pos_nxt   = '0;
          state_nxt = sidd_pkg::ST_CONV;
        end
      end
      sidd_pkg::ST_CONV: begin
        {bcd_nxt, bin_nxt} = {bcd_adj, bin_r} << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = sidd_pkg::ST_EMIT;
        end
      end
      sidd_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          opos_nxt      = pos_r;
          if (sign_r) begin
            digit_nxt = sidd_pkg::MINUS_CODE;
            last_nxt  = 1'b1;
            state_nxt = sidd_pkg::ST_IDLE;
          end else begin
            digit_nxt = bcd_r[3:0];
            bcd_nxt   = bcd_rest;
            if (bcd_rest == '0 && !(neg_r && !at_max)) begin
              last_nxt  = 1'b1;
              state_nxt = sidd_pkg::ST_IDLE;
            end else if (at_max) begin
              last_nxt  = 1'b1;
              state_nxt = sidd_pkg::ST_IDLE;
            end else begin
              last_nxt = 1'b0;
              pos_nxt  = pos_r + 3'd1;
              sign_nxt = (bcd_rest == '0);
            end
          end
        end
      end
      default: begin
        state_nxt = sidd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sidd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    sign_r  <= sign_nxt;
    pos_r   <= pos_nxt;
    digit_r <= digit_nxt;
    opos_r  <= opos_nxt;
    last_r  <= last_nxt;
  end

`include "signed_int_to_decimal_digits_unit_assert.svh"

  `SIDD_ASSERT_NXT(a_accept_starts_conv, in_valid && in_ready, state_r == sidd_pkg::ST_CONV)
  `SIDD_ASSERT_IMP(a_minus_is_last, out_valid && out_digit == sidd_pkg::MINUS_CODE, out_last)
  `SIDD_ASSERT_IMP(a_pos_in_range, out_valid, out_position <= sidd_pkg::LAST_POS)
  `SIDD_ASSERT_IMP(a_pos_max_is_last, out_valid && out_position == sidd_pkg::LAST_POS, out_last)

endmodule

### verif/decimal_digit_checker.sv
// Checker for the signed decimal digit unit: predicts the digit words of every
// accepted number and compares them with the words leaving the block.
// Depends on sidd_pkg for the field widths, the minus code and the last position.
module decimal_digit_checker #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [VALUE_WIDTH-1:0]       in_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [sidd_pkg::DIGIT_W-1:0] out_digit,
  input  logic [sidd_pkg::POS_W-1:0]   out_position,
  input  logic                         out_last,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sidd_pkg::DIGIT_W-1:0] digit;
    logic [sidd_pkg::POS_W-1:0]   position;
    logic                         last;
  } digit_word_t;

  localparam int MAX_RUN = int'(sidd_pkg::LAST_POS) + 1;

  digit_word_t expected_words[$];
  int unsigned errors = 0;

  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value);
    logic [VALUE_WIDTH:0] magnitude;
    logic                 negative;
    digit_word_t          run [MAX_RUN];
    int                   count;
    negative  = value[VALUE_WIDTH-1];
    magnitude = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
    count     = 0;
    if (magnitude == 0) begin
      run[0].digit = '0;
      count = 1;
    end else begin
      while (magnitude != 0 && count < MAX_RUN) begin
        run[count].digit = sidd_pkg::DIGIT_W'(magnitude % 10);
        magnitude = (VALUE_WIDTH + 1)'(magnitude / 10);
        count++;
      end
      if (negative && count < MAX_RUN) begin
        run[count].digit = sidd_pkg::MINUS_CODE;
        count++;
      end
    end
    for (int i = 0; i < count; i++) begin
      run[i].position = sidd_pkg::POS_W'(i);
      run[i].last     = (i == count - 1);
      expected_words.push_back(run[i]);
    end
  endfunction

  always @(posedge clk) begin : compare_words
    digit_word_t head;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("[%0t] unexpected word: digit %0d position %0d last %0b",
                     $realtime, out_digit, out_position, out_last);
          end
        end else begin
          head = expected_words.pop_front();
          if (out_digit !== head.digit || out_position !== head.position ||
              out_last !== head.last) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] word mismatch: expected digit %0d position %0d last %0b,",
                       $realtime, head.digit, head.position, head.last);
              $display("    got digit %0d position %0d last %0b",
                       out_digit, out_position, out_last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_digits(in_value);
      end
    end
    fail_count <= errors;
    pending    <= unsigned'(expected_words.size());
  end

endmodule

### verif/signed_int_to_decimal_digits_unit_tb.sv
// Top of the signed decimal digit unit testbench: clock, reset, number stimulus
// in bursts, output back-pressure, watchdog and verdict.
// Depends on signed_int_to_decimal_digits_unit and decimal_digit_checker.
module signed_int_to_decimal_digits_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH  = 16;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned IDLE_LIMIT   = 4000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic [VALUE_WIDTH-1:0] in_value  = '0;
  logic                   out_ready = 1'b0;
  logic                   in_ready;
  logic                   out_valid;
  logic [3:0]             out_digit;
  logic [2:0]             out_position;
  logic                   out_last;
  int unsigned            fail_count;
  int unsigned            pending;

  logic [VALUE_WIDTH-1:0] numbers[$];
  int unsigned            idle_cycles = 0;
  int unsigned            stall_mode  = 0;
  int unsigned            mode_left   = 0;
  int unsigned            phase       = 0;

  always #6 clk = ~clk;

  signed_int_to_decimal_digits_unit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_digit   (out_digit),
    .out_position(out_position),
    .out_last    (out_last)
  );

  decimal_digit_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_digit   (out_digit),
    .out_position(out_position),
    .out_last    (out_last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    phase <= phase + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= (phase[2:0] == 3'd0);
      default: out_ready <= ((phase % 7) < 3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [VALUE_WIDTH-1:0] random_number();
    int magnitude;
    int scale;
    scale = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: magnitude = int'(VALUE_WIDTH'($urandom));
      4: magnitude = $urandom_range(0, 99);
      5: begin
        repeat ($urandom_range(0, 4)) scale *= 10;
        magnitude = scale + $urandom_range(0, 2) - 1;
      end
      6: magnitude = ($urandom_range(0, 1) == 1) ? 32768 : 32767;
      default: begin
        repeat ($urandom_range(1, 4)) scale *= 10;
        magnitude = $urandom_range(0, scale - 1);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      magnitude = -magnitude;
    end
    return VALUE_WIDTH'(magnitude);
  endfunction

  task automatic send_numbers();
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < numbers.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < numbers.size()) begin
        in_valid <= 1'b1;
        in_value <= numbers[idx];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0 || idx == numbers.size()) begin
        in_valid <= 1'b0;
        in_value <= VALUE_WIDTH'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    numbers = '{16'd0, 16'd1, -16'sd1, 16'd9, -16'sd9, 16'd10, -16'sd10, 16'd99,
                16'd100, -16'sd100, 16'd999, 16'd1000, 16'd9999, 16'd10000,
                -16'sd10000, 16'h7FFF, -16'sd32767, 16'h8000, 16'd12345,
                -16'sd12345, 16'h5555, 16'hAAAA, 16'd30000, -16'sd1000, 16'd5};
    repeat (RANDOM_WORDS) numbers.push_back(random_number());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_numbers();

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
